>>> hdl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mme_pkg;

  localparam int MAX_DIM_DEF     = 8;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int IDX_W           = 3;
  localparam int DIM_W           = 4;
  localparam int FIELD_W         = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    CFG_A_ROWS    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_B_COLS    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_code_t                  cmd;
    logic [IDX_W-1:0]           elem_row;
    logic [IDX_W-1:0]           elem_col;
    logic signed [FIELD_W-1:0]  elem_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]           out_row;
    logic [IDX_W-1:0]           out_col;
    logic signed [FIELD_W-1:0]  product_value;
    logic                       last;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_valid;
    logic             first;
    logic             last_term;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pipe_active;
  } dp_stat_t;

endpackage

>>> hdl/mme_ctrl.sv
// Controller of the matrix multiply engine: configuration registers, request decode
// and the sequencer that walks rows, columns and inner terms. Depends on mme_pkg.
module mme_ctrl #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  mme_pkg::in_req_t         in_req,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [mme_pkg::DIM_W-1:0] cfg_wdata,
  output mme_pkg::dp_cmd_t         cmd,
  input  mme_pkg::dp_stat_t        stat
);

  localparam int IW = mme_pkg::IDX_W;
  localparam int DW = mme_pkg::DIM_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t         state_r, state_nxt;
  logic [DW-1:0]  a_rows_r, a_rows_nxt;
  logic [DW-1:0]  inner_dim_r, inner_dim_nxt;
  logic [DW-1:0]  b_cols_r, b_cols_nxt;
  logic [DW-1:0]  m_r, m_nxt;
  logic [DW-1:0]  n_r, n_nxt;
  logic [DW-1:0]  p_r, p_nxt;
  logic [IW-1:0]  i_r, i_nxt;
  logic [IW-1:0]  j_r, j_nxt;
  logic [IW-1:0]  k_r, k_nxt;
  logic           accept;
  logic           in_range;
  logic           last_k, last_j, last_i;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (d > DW'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == ST_RUN) || stat.pipe_active;
  assign accept    = start && !busy;
  assign in_range  = ({1'b0, in_req.elem_row} < (IW+1)'(MAX_DIM)) &&
                     ({1'b0, in_req.elem_col} < (IW+1)'(MAX_DIM));

  assign last_k = ({1'b0, k_r} == n_r - DW'(1));
  assign last_j = ({1'b0, j_r} == p_r - DW'(1));
  assign last_i = ({1'b0, i_r} == m_r - DW'(1));

  always_comb begin
    cmd           = '0;
    cmd.wr_a      = accept && in_range && (in_req.cmd == mme_pkg::CMD_LOAD_A);
    cmd.wr_b      = accept && in_range && (in_req.cmd == mme_pkg::CMD_LOAD_B);
    cmd.rd_valid  = (state_r == ST_RUN);
    cmd.first     = (k_r == '0);
    cmd.last_term = last_k;
    cmd.last_elem = last_k && last_j && last_i;
    cmd.row       = i_r;
    cmd.col       = j_r;
    cmd.k         = k_r;
  end

  always_comb begin
    a_rows_nxt    = a_rows_r;
    inner_dim_nxt = inner_dim_r;
    b_cols_nxt    = b_cols_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mme_pkg::CFG_A_ROWS:    a_rows_nxt    = cfg_wdata;
        mme_pkg::CFG_INNER_DIM: inner_dim_nxt = cfg_wdata;
        mme_pkg::CFG_B_COLS:    b_cols_nxt    = cfg_wdata;
        default:                ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req.cmd == mme_pkg::CMD_COMPUTE) begin
          m_nxt     = clamp_dim(a_rows_r);
          n_nxt     = clamp_dim(inner_dim_r);
          p_nxt     = clamp_dim(b_cols_r);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last_k) begin
          k_nxt = k_r + IW'(1);
        end else begin
          k_nxt = '0;
          if (!last_j) begin
            j_nxt = j_r + IW'(1);
          end else begin
            j_nxt = '0;
            if (!last_i) begin
              i_nxt = i_r + IW'(1);
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_rows_r    <= DW'(2);
      inner_dim_r <= DW'(2);
      b_cols_r    <= DW'(2);
      m_r         <= DW'(1);
      n_r         <= DW'(1);
      p_r         <= DW'(1);
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      a_rows_r    <= a_rows_nxt;
      inner_dim_r <= inner_dim_nxt;
      b_cols_r    <= b_cols_nxt;
      m_r         <= m_nxt;
      n_r         <= n_nxt;
      p_r         <= p_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
  end

  // The walk never reads past the latched dimensions.
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_valid |-> ({1'b0, cmd.k} < n_r))
    else $error("inner index beyond inner dimension");

  // Store writes only happen while no product walk is running.
  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_a || cmd.wr_b) |-> (state_r == ST_IDLE))
    else $error("store write during product walk");

  // The final read of the walk ends the run on the next cycle.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_valid && cmd.last_elem) |=> (state_r == ST_IDLE))
    else $error("walk continued past final element");

  // The final element is always the last term of its sum.
  a_last_elem_term: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last_elem |-> cmd.last_term)
    else $error("final element flagged mid-sum");

endmodule

>>> hdl/mme_dp.sv
// Datapath of the matrix multiply engine: the two element stores, the multiplier,
// the wide accumulator and the shift-and-saturate output stage. Depends on mme_pkg.
module mme_dp #(
  parameter int MAX_DIM     = mme_pkg::MAX_DIM_DEF,
  parameter int VALUE_WIDTH = mme_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mme_pkg::in_req_t   in_req,
  input  mme_pkg::dp_cmd_t   cmd,
  output mme_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output mme_pkg::out_res_t  out_res
);

  localparam int IW      = mme_pkg::IDX_W;
  localparam int FRAC    = mme_pkg::FRAC_BITS;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W  = 2 * VALUE_WIDTH;
  localparam int SUM_W   = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int ACC_W   = (SUM_W > VALUE_WIDTH + FRAC + 1) ? SUM_W : VALUE_WIDTH + FRAC + 1;
  localparam int SH_W    = ACC_W - FRAC;

  logic signed [VALUE_WIDTH-1:0] mem_a [DEPTH];
  logic signed [VALUE_WIDTH-1:0] mem_b [DEPTH];

  logic [AW-1:0]                 wr_addr, rd_addr_a, rd_addr_b;
  logic signed [VALUE_WIDTH-1:0] wr_value;

  // Stage 1: registered store reads.
  logic signed [VALUE_WIDTH-1:0] a_q_r, b_q_r;
  logic                          v1_r;
  logic                          first1_r, term1_r, elem1_r;
  logic [IW-1:0]                 row1_r, col1_r;
  // Stage 2: product.
  logic signed [PROD_W-1:0]      prod_r;
  logic                          v2_r;
  logic                          first2_r, term2_r, elem2_r;
  logic [IW-1:0]                 row2_r, col2_r;
  // Stage 3: accumulation.
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          v3_r;
  logic                          elem3_r;
  logic [IW-1:0]                 row3_r, col3_r;
  // Stage 4: saturated result.
  logic                          out_valid_r;
  mme_pkg::out_res_t             out_res_r, out_res_nxt;

  logic signed [SH_W-1:0]        shifted;
  logic [SH_W-VALUE_WIDTH:0]     top_bits;
  logic signed [VALUE_WIDTH-1:0] sat;

  assign wr_addr   = AW'(in_req.elem_row) * AW'(MAX_DIM) + AW'(in_req.elem_col);
  assign rd_addr_a = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.k);
  assign rd_addr_b = AW'(cmd.k) * AW'(MAX_DIM) + AW'(cmd.col);
  assign wr_value  = in_req.elem_value[VALUE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= wr_value;
    end
    if (cmd.rd_valid) begin
      a_q_r <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= wr_value;
    end
    if (cmd.rd_valid) begin
      b_q_r <= mem_b[rd_addr_b];
    end
  end

  assign acc_nxt = first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  // Floor shift, then clamp when the result's sign bit and the bits above it disagree.
  assign shifted  = SH_W'(acc_r >>> FRAC);
  assign top_bits = shifted[SH_W-1:VALUE_WIDTH-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sat = shifted[VALUE_WIDTH-1:0];
    end else if (shifted[SH_W-1]) begin
      sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
    out_res_nxt               = '0;
    out_res_nxt.out_row       = row3_r;
    out_res_nxt.out_col       = col3_r;
    out_res_nxt.product_value = mme_pkg::FIELD_W'(sat);
    out_res_nxt.last          = elem3_r;
  end

  always_ff @(posedge clk) begin
    first1_r  <= cmd.first;
    term1_r   <= cmd.last_term;
    elem1_r   <= cmd.last_elem;
    row1_r    <= cmd.row;
    col1_r    <= cmd.col;
    prod_r    <= a_q_r * b_q_r;
    first2_r  <= first1_r;
    term2_r   <= term1_r;
    elem2_r   <= elem1_r;
    row2_r    <= row1_r;
    col2_r    <= col1_r;
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
    elem3_r   <= elem2_r;
    row3_r    <= row2_r;
    col3_r    <= col2_r;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.rd_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r && term2_r;
      out_valid_r <= v3_r;
    end
  end

  assign stat.pipe_active = v1_r || v2_r || v3_r;
  assign out_valid        = out_valid_r;
  assign out_res          = out_res_r;

  // A finished sum always turns into exactly one result in the next cycle.
  a_sum_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |=> out_valid_r)
    else $error("finished sum did not produce a result");

  // A result only follows a valid product from the read walk.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(v2_r, 2))
    else $error("result without a preceding read");

  // The pipeline reports activity whenever a sum is in flight.
  a_active_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> stat.pipe_active)
    else $error("pipeline activity not reported");

endmodule

>>> hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: joins controller and datapath.
// Depends on mme_pkg, mme_ctrl and mme_dp.
//
// Usage. A request on in_req is taken at a rising edge where start is high and
// busy is low. Command load A or load B writes elem_value into the given row and
// column of that matrix's store; loads with an index at or beyond
// MAX_DIM are dropped, and loads give no result. A compute request walks the
// product C = A * B in row-major order, one multiply-accumulate per cycle, and
// presents each element of C on out_res for exactly one cycle with out_valid
// high; the final element carries last. The receiver cannot hold results off,
// so every strobed result must be captured in its cycle.
//
// Busy. A compute request keeps busy high while the sequencer walks the
// product and while any of its reads is still in the datapath pipeline;
// each result appears once its sum over the inner dimension is complete. The
// pace is set by the single read port of each store feeding one multiplier.
// Loads may follow back to back.
//
// Configuration. cfg_index selects a_rows, inner_dim or b_cols and cfg_wdata is
// written whenever cfg_valid is high (cfg_ready is always high); a value of zero
// acts as one and values above MAX_DIM act as MAX_DIM. Reset sets all three to
// two and idles the sequencer; store contents are undefined until loaded.
module matrix_multiply_engine #(
  parameter int MAX_DIM     = mme_pkg::MAX_DIM_DEF,
  parameter int VALUE_WIDTH = mme_pkg::VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  mme_pkg::in_req_t          in_req,
  output logic                      out_valid,
  output mme_pkg::out_res_t         out_res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [mme_pkg::DIM_W-1:0] cfg_wdata
);

  // Command and status buses between the sequencer and the datapath.
  mme_pkg::dp_cmd_t  dp_cmd;
  mme_pkg::dp_stat_t dp_stat;

  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  mme_dp #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> tb/matrix_multiply_engine_tb.sv
`timescale 1ns / 100ps
// Testbench for matrix_multiply_engine. It loads the operand stores, sends compute
// requests under several dimension settings and checks every product element.
// Depends on mme_pkg and the engine RTL only.
module matrix_multiply_engine_tb;

  localparam int DIM            = mme_pkg::MAX_DIM_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int ITEM_TARGET    = 160;

  // Saturation bounds of a Q16.16 result, held at the width of the wide sum.
  localparam logic signed [79:0] SUM_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SUM_MIN = -80'sh8000_0000;
  localparam logic signed [mme_pkg::FIELD_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [mme_pkg::FIELD_W-1:0] Q_MIN      = 32'sh8000_0000;
  localparam logic signed [mme_pkg::FIELD_W-1:0] Q_ONE      = 32'sh0001_0000;
  localparam logic signed [mme_pkg::FIELD_W-1:0] Q_ONE_HALF = 32'sh0001_8000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  mme_pkg::in_req_t          in_req;
  logic                      out_valid;
  mme_pkg::out_res_t         out_res;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [mme_pkg::DIM_W-1:0] cfg_wdata;

  // Shadow copy of the engine: both operand stores, which entries have been
  // loaded since reset, and the three dimension registers.
  logic signed [mme_pkg::FIELD_W-1:0] mat_a [DIM][DIM];
  logic signed [mme_pkg::FIELD_W-1:0] mat_b [DIM][DIM];
  bit                                 a_loaded [DIM][DIM];
  bit                                 b_loaded [DIM][DIM];
  logic [mme_pkg::DIM_W-1:0]          rows_reg  = 4'd2;
  logic [mme_pkg::DIM_W-1:0]          inner_reg = 4'd2;
  logic [mme_pkg::DIM_W-1:0]          cols_reg  = 4'd2;

  // Product elements predicted but not yet seen on the result port, oldest first.
  mme_pkg::out_res_t pending_products [$];

  int  error_count   = 0;
  int  load_count    = 0;
  int  compute_count = 0;
  int  product_count = 0;
  int  cfg_count     = 0;
  int  sent_count    = 0;
  int  quiet_cycles  = 0;
  bit  gaps_on       = 1'b1;

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A register value of zero acts as one and anything above the store size acts
  // as the store size.
  function automatic int unsigned eff_dim(input logic [mme_pkg::DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM) return DIM;
    return raw;
  endfunction

  // Works out every element of C = A * B for the current dimensions. Each term is
  // the exact 64-bit product; the sum is kept at 80 bits so eight terms of the
  // largest magnitude cannot wrap. The arithmetic shift floors toward minus
  // infinity, and the result is then clipped to the Q16.16 range.
  function automatic void predict_products();
    int unsigned m, n, p;
    logic signed [63:0] term;
    logic signed [79:0] acc;
    mme_pkg::out_res_t elem;
    m = eff_dim(rows_reg);
    n = eff_dim(inner_reg);
    p = eff_dim(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < p; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          term = mat_a[i][k] * mat_b[k][j];
          acc += term;
        end
        acc = acc >>> mme_pkg::FRAC_BITS;
        elem.out_row = mme_pkg::IDX_W'(i);
        elem.out_col = mme_pkg::IDX_W'(j);
        if (acc > SUM_MAX) elem.product_value = Q_MAX;
        else if (acc < SUM_MIN) elem.product_value = Q_MIN;
        else elem.product_value = acc[mme_pkg::FIELD_W-1:0];
        elem.last = (i == m - 1) && (j == p - 1);
        pending_products.push_back(elem);
      end
    end
  endfunction

  // Applies one accepted request to the shadow state. Loads give no result and
  // the unused command code does nothing at all.
  function automatic void track_request(input mme_pkg::in_req_t req);
    case (req.cmd)
      mme_pkg::CMD_LOAD_A: begin
        mat_a[req.elem_row][req.elem_col]    = req.elem_value;
        a_loaded[req.elem_row][req.elem_col] = 1'b1;
        load_count++;
      end
      mme_pkg::CMD_LOAD_B: begin
        mat_b[req.elem_row][req.elem_col]    = req.elem_value;
        b_loaded[req.elem_row][req.elem_col] = 1'b1;
        load_count++;
      end
      mme_pkg::CMD_COMPUTE: begin
        predict_products();
        compute_count++;
      end
      default: ;
    endcase
  endfunction

  // Element values: mostly small and medium Q16.16 numbers so that many sums stay
  // inside the range or land near its edges, plus the extremes and raw random
  // words that drive the saturation paths.
  function automatic logic signed [mme_pkg::FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom;
      12, 13,
      14, 15:  return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  // Dimension register values: small sizes most of the time, now and then zero or
  // a large value, which may lie above the store size.
  function automatic logic [mme_pkg::DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mme_pkg::DIM_W'($urandom_range(4, 15));
      default: return mme_pkg::DIM_W'($urandom_range(1, 3));
    endcase
  endfunction

  // Sends one request. Inputs change on the falling edge; the request is taken at
  // the first rising edge where start is high and busy is low. Start stays high
  // after acceptance until the next falling edge, where either the next request
  // takes over or a gap begins, so start gets a single assignment per step.
  task automatic issue_request(input mme_pkg::cmd_code_t cmd,
                               input logic [mme_pkg::IDX_W-1:0] row,
                               input logic [mme_pkg::IDX_W-1:0] col,
                               input logic signed [mme_pkg::FIELD_W-1:0] value);
    mme_pkg::in_req_t req;
    int               gap;
    req.cmd        = cmd;
    req.elem_row   = row;
    req.elem_col   = col;
    req.elem_value = value;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_request(req);
    sent_count++;
  endtask

  // Holds the sender off until every predicted element has arrived and the engine
  // has dropped busy, then waits on for a settling time, since a trailing load
  // leaves nothing to wait for on the result side.
  task automatic wait_for_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_products.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the engine idle.
  task automatic program_register(input mme_pkg::cfg_idx_t idx,
                                  input logic [mme_pkg::DIM_W-1:0] value);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mme_pkg::CFG_A_ROWS:    rows_reg  = value;
      mme_pkg::CFG_INNER_DIM: inner_reg = value;
      mme_pkg::CFG_B_COLS:    cols_reg  = value;
      default: ;
    endcase
    cfg_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dims(input logic [mme_pkg::DIM_W-1:0] rows,
                          input logic [mme_pkg::DIM_W-1:0] inner,
                          input logic [mme_pkg::DIM_W-1:0] cols);
    program_register(mme_pkg::CFG_A_ROWS, rows);
    program_register(mme_pkg::CFG_INNER_DIM, inner);
    program_register(mme_pkg::CFG_B_COLS, cols);
  endtask

  // Store contents are undefined until written, so before any compute every entry
  // that the current dimensions will read gets loaded if it never was.
  task automatic load_missing_operands();
    int unsigned m, n, p;
    m = eff_dim(rows_reg);
    n = eff_dim(inner_reg);
    p = eff_dim(cols_reg);
    for (int i = 0; i < m; i++)
      for (int k = 0; k < n; k++)
        if (!a_loaded[i][k])
          issue_request(mme_pkg::CMD_LOAD_A, mme_pkg::IDX_W'(i), mme_pkg::IDX_W'(k),
                        pick_value());
    for (int k = 0; k < n; k++)
      for (int j = 0; j < p; j++)
        if (!b_loaded[k][j])
          issue_request(mme_pkg::CMD_LOAD_B, mme_pkg::IDX_W'(k), mme_pkg::IDX_W'(j),
                        pick_value());
  endtask

  task automatic issue_compute();
    issue_request(mme_pkg::CMD_COMPUTE, mme_pkg::IDX_W'($urandom),
                  mme_pkg::IDX_W'($urandom), $urandom);
  endtask

  // Reset dimensions (two by two by two) with extreme operands. The top row of C
  // saturates high and low, the bottom left element saturates after adding a
  // small negative-times-negative term, and the bottom right one checks flooring
  // of a small negative sum. The unused command code is sent around the compute.
  task automatic test_reset_config();
    issue_request(mme_pkg::CMD_LOAD_A, 3'd0, 3'd0, Q_MAX);
    issue_request(mme_pkg::CMD_LOAD_A, 3'd0, 3'd1, Q_MIN);
    issue_request(mme_pkg::CMD_LOAD_A, 3'd1, 3'd0, Q_ONE);
    issue_request(mme_pkg::CMD_LOAD_A, 3'd1, 3'd1, '1);
    issue_request(mme_pkg::CMD_LOAD_B, 3'd0, 3'd0, Q_MAX);
    issue_request(mme_pkg::CMD_LOAD_B, 3'd0, 3'd1, '1);
    issue_request(mme_pkg::CMD_LOAD_B, 3'd1, 3'd0, Q_MIN);
    issue_request(mme_pkg::CMD_LOAD_B, 3'd1, 3'd1, Q_ONE_HALF);
    issue_request(mme_pkg::CMD_NOP, 3'd7, 3'd7, '1);
    issue_compute();
    issue_request(mme_pkg::CMD_NOP, 3'd0, 3'd0, '0);
  endtask

  // Zero in every register behaves as a single-element product. A write to the
  // unused register index must change nothing. A row count above the store size
  // acts as the store size.
  task automatic test_dim_clamping();
    set_dims('0, '0, '0);
    issue_compute();
    program_register(mme_pkg::CFG_UNUSED, '1);
    issue_compute();
    set_dims(4'd15, 4'd1, 4'd3);
    load_missing_operands();
    issue_compute();
  endtask

  // Largest product, 8 x 8 x 8 (a column count of 9 acts as 8); every entry still
  // unloaded is loaded back to back, with the far corner at row 7 and column 7.
  task automatic test_full_size();
    gaps_on = 1'b0;
    set_dims(4'd8, 4'd8, 4'd9);
    load_missing_operands();
    issue_compute();
    gaps_on = 1'b1;
  endtask

  // Random traffic: mostly batches of loads followed by a compute, sometimes a
  // compute with no new loads, some unused commands as noise, and occasional
  // dimension changes or full drains between batches. It runs until the whole
  // test has sent its share of requests.
  task automatic test_random_traffic();
    while (sent_count < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) set_dims(random_dim(), random_dim(), random_dim());
      else if ($urandom_range(0, 4) == 0) wait_for_idle();
      repeat ($urandom_range(0, 6)) begin
        issue_request($urandom_range(0, 1) ? mme_pkg::CMD_LOAD_B : mme_pkg::CMD_LOAD_A,
                      mme_pkg::IDX_W'($urandom), mme_pkg::IDX_W'($urandom), pick_value());
      end
      if ($urandom_range(0, 4) == 0)
        issue_request(mme_pkg::CMD_NOP, mme_pkg::IDX_W'($urandom),
                      mme_pkg::IDX_W'($urandom), $urandom);
      load_missing_operands();
      issue_compute();
    end
  endtask

  // Every strobed result is compared with the oldest prediction. The engine cannot
  // be held off, so each result is taken in the cycle it is shown.
  always @(posedge clk) begin
    mme_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (pending_products.size() == 0) begin
        $error("unexpected product element at row %0d col %0d", out_res.out_row,
               out_res.out_col);
        error_count++;
      end else begin
        want = pending_products.pop_front();
        product_count++;
        if (out_res.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_res.out_row);
          error_count++;
        end
        if (out_res.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_res.out_col);
          error_count++;
        end
        if (out_res.product_value !== want.product_value) begin
          $error("product_value: expected %0d, got %0d", want.product_value,
                 out_res.product_value);
          error_count++;
        end
        if (out_res.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_res.last);
          error_count++;
        end
      end
    end
  end

  // Ends the run if nothing is accepted on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = mme_pkg::CFG_A_ROWS;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_dim_clamping();
    test_full_size();
    test_random_traffic();
    wait_for_idle();

    $display("tb: covered %0d requests: %0d operand loads, %0d compute requests, %0d %s",
             sent_count, load_count, compute_count, cfg_count, "register writes");
    $display("tb: %0d product elements compared, %0d mismatches", product_count,
             error_count);
    if (error_count == 0 && pending_products.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
